@@ sv/bps_pkg.sv @@
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants, codes and state type for the bitmap priority scheduler.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int NUM_PRIOS = 32;
    localparam int TICK_BITS = 32;

    localparam int CMD_W     = 2;
    localparam int PRIO_W    = 6;
    localparam int DELAY_W   = 32;
    localparam int THREAD_W  = 6;
    localparam int MASK_W    = 32;
    localparam int ERR_W     = 2;

    localparam int IDX_W     = $clog2(NUM_PRIOS);
    localparam int CNT_W     = $clog2(NUM_PRIOS + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_DELAY = 2'd1,
        CMD_START = 2'd2,
        CMD_SCHED = 2'd3
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 2'd0,
        ERR_NO_THREAD  = 2'd1,
        ERR_SLOT_TAKEN = 2'd2,
        ERR_ZERO_DELAY = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_SCHED,
        S_DONE
    } state_t;

endpackage

@@ sv/bps_req_if.sv @@
// ----------------------------------------------------------------------------
// bps_req_if
// Command channel: one beat carries one scheduler command.
// ----------------------------------------------------------------------------
interface bps_req_if;

    logic                        valid;
    logic                        ready;
    logic [bps_pkg::CMD_W-1:0]   cmd;
    logic [bps_pkg::PRIO_W-1:0]  prio;
    logic [bps_pkg::DELAY_W-1:0] delay_ticks;

    modport source (output valid, output cmd, output prio, output delay_ticks, input ready);
    modport sink   (input valid, input cmd, input prio, input delay_ticks, output ready);

endinterface

@@ sv/bps_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bps_rsp_if
// Result channel: one beat carries the outcome of one command.
// ----------------------------------------------------------------------------
interface bps_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [bps_pkg::THREAD_W-1:0] next_thread;
    logic                         switch_now;
    logic [bps_pkg::MASK_W-1:0]   ready_mask;
    logic [bps_pkg::ERR_W-1:0]    error_code;

    modport source (output valid, output next_thread, output switch_now,
                    output ready_mask, output error_code, input ready);
    modport sink   (input valid, input next_thread, input switch_now,
                    input ready_mask, input error_code, output ready);

endinterface

@@ sv/bitmap_priority_scheduler.sv @@
// From accept to result: start commands and rejected delay commands go straight to the result state;
// schedule and delay first scan the ready bitmap, and tick first walks the timeout RAM.
// One command at a time; the next is taken while a result waits in the output register.
// Tick time is set by the walk over the timeout RAM, one entry per cycle through its read port;
// schedule time by the scan of the ready bitmap, one priority per cycle.
// Reset clears all bitmaps and the running thread; the timeout RAM is not cleared.
// ----------------------------------------------------------------------------
// bitmap_priority_scheduler
// Thread scheduler with ready and delayed bitmaps and per-priority tick
// timeouts held in a RAM, updated by read-modify-write.
// ----------------------------------------------------------------------------
module bitmap_priority_scheduler (
    input  logic   clk,
    input  logic   rst_n,
    bps_req_if.sink   req,
    bps_rsp_if.source rsp
);

    localparam int N = bps_pkg::NUM_PRIOS;

    bps_pkg::state_t state_reg, state_next;

    logic [N-1:0]                    ready_bits_reg, ready_bits_next;
    logic [N-1:0]                    delayed_bits_reg, delayed_bits_next;
    logic [N-1:0]                    slots_reg, slots_next;
    logic                            idle_reg, idle_next;
    logic [bps_pkg::CNT_W-1:0]       cur_reg, cur_next;
    logic                            cur_valid_reg, cur_valid_next;

    logic [bps_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [bps_pkg::CNT_W-1:0]       best_reg, best_next;
    logic                            pipe_vld_reg, pipe_vld_next;
    logic [bps_pkg::IDX_W-1:0]       pipe_idx_reg, pipe_idx_next;
    logic                            res_sw_reg, res_sw_next;
    bps_pkg::err_t                   res_err_reg, res_err_next;

    logic                            out_vld_reg, out_vld_next;
    logic [bps_pkg::THREAD_W-1:0]    out_thread_reg, out_thread_next;
    logic                            out_sw_reg, out_sw_next;
    logic [bps_pkg::MASK_W-1:0]      out_mask_reg, out_mask_next;
    bps_pkg::err_t                   out_err_reg, out_err_next;

    logic                            ram_wr_en;
    logic [bps_pkg::IDX_W-1:0]       ram_wr_addr;
    logic [bps_pkg::TICK_BITS-1:0]   ram_wr_data;
    logic                            ram_rd_en;
    logic [bps_pkg::IDX_W-1:0]       ram_rd_addr;
    logic [bps_pkg::TICK_BITS-1:0]   ram_rd_data;

    logic                            accept;
    logic                            out_free;
    logic                            scan_done;
    logic                            tick_done;
    logic [bps_pkg::MASK_W-1:0]      ready_mask_full;

    bps_ram #(
        .WIDTH (bps_pkg::TICK_BITS),
        .DEPTH (N)
    ) u_timeouts (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    genvar b;
    generate
        for (b = 0; b < bps_pkg::MASK_W; b++)
        begin : g_mask
            if (b < N)
            begin : g_live
                assign ready_mask_full[b] = ready_bits_reg[b];
            end
            else
            begin : g_pad
                assign ready_mask_full[b] = 1'b0;
            end
        end
    endgenerate

    assign accept    = req.valid && req.ready;
    assign out_free  = !out_vld_reg || rsp.ready;
    assign scan_done = (idx_reg == bps_pkg::CNT_W'(N));
    assign tick_done = scan_done && !pipe_vld_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bps_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (bps_pkg::cmd_t'(req.cmd))
                        bps_pkg::CMD_TICK:  state_next = bps_pkg::S_TICK;
                        bps_pkg::CMD_SCHED: state_next = bps_pkg::S_SCHED;
                        bps_pkg::CMD_DELAY:
                        begin
                            if (!cur_valid_reg || cur_reg == '0 ||
                                int'(cur_reg) > N ||
                                req.delay_ticks[bps_pkg::TICK_BITS-1:0] == '0)
                            begin
                                state_next = bps_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = bps_pkg::S_SCHED;
                            end
                        end
                        default:            state_next = bps_pkg::S_DONE;
                    endcase
                end
            end
            bps_pkg::S_TICK:
            begin
                if (tick_done)
                begin
                    state_next = bps_pkg::S_DONE;
                end
            end
            bps_pkg::S_SCHED:
            begin
                if (scan_done)
                begin
                    state_next = bps_pkg::S_DONE;
                end
            end
            bps_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bps_pkg::S_IDLE;
                end
            end
            default: state_next = bps_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [bps_pkg::PRIO_W-1:0]    prio_m1;
        logic [bps_pkg::IDX_W-1:0]     prio_idx;
        logic [bps_pkg::CNT_W-1:0]     cur_m1;
        logic [bps_pkg::IDX_W-1:0]     cur_idx;
        logic [bps_pkg::TICK_BITS-1:0] ticks;
        logic [bps_pkg::TICK_BITS-1:0] tval;
        logic                          nvalid;
        logic [bps_pkg::CNT_W-1:0]     nid;

        ready_bits_next   = ready_bits_reg;
        delayed_bits_next = delayed_bits_reg;
        slots_next        = slots_reg;
        idle_next         = idle_reg;
        cur_next          = cur_reg;
        cur_valid_next    = cur_valid_reg;
        idx_next          = idx_reg;
        best_next         = best_reg;
        pipe_vld_next     = 1'b0;
        pipe_idx_next     = pipe_idx_reg;
        res_sw_next       = res_sw_reg;
        res_err_next      = res_err_reg;
        out_vld_next      = out_vld_reg && !rsp.ready;
        out_thread_next   = out_thread_reg;
        out_sw_next       = out_sw_reg;
        out_mask_next     = out_mask_reg;
        out_err_next      = out_err_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = '0;
        ram_wr_data       = '0;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = '0;

        prio_m1  = req.prio - bps_pkg::PRIO_W'(1);
        prio_idx = prio_m1[bps_pkg::IDX_W-1:0];
        cur_m1   = cur_reg - bps_pkg::CNT_W'(1);
        cur_idx  = cur_m1[bps_pkg::IDX_W-1:0];
        ticks    = req.delay_ticks[bps_pkg::TICK_BITS-1:0];
        tval     = ram_rd_data;
        nvalid   = 1'b0;
        nid      = '0;

        case (state_reg)
            bps_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = '0;
                    best_next    = '0;
                    res_sw_next  = 1'b0;
                    res_err_next = bps_pkg::ERR_OK;
                    case (bps_pkg::cmd_t'(req.cmd))
                        bps_pkg::CMD_DELAY:
                        begin
                            if (!cur_valid_reg || cur_reg == '0 || int'(cur_reg) > N)
                            begin
                                res_err_next = bps_pkg::ERR_NO_THREAD;
                            end
                            else if (ticks == '0)
                            begin
                                res_err_next = bps_pkg::ERR_ZERO_DELAY;
                            end
                            else
                            begin
                                ram_wr_en                  = 1'b1;
                                ram_wr_addr                = cur_idx;
                                ram_wr_data                = ticks;
                                ready_bits_next[cur_idx]   = 1'b0;
                                delayed_bits_next[cur_idx] = 1'b1;
                            end
                        end
                        bps_pkg::CMD_START:
                        begin
                            if (int'(req.prio) > N)
                            begin
                                res_err_next = bps_pkg::ERR_SLOT_TAKEN;
                            end
                            else if (req.prio == '0)
                            begin
                                if (idle_reg)
                                begin
                                    res_err_next = bps_pkg::ERR_SLOT_TAKEN;
                                end
                                else
                                begin
                                    idle_next = 1'b1;
                                end
                            end
                            else if (slots_reg[prio_idx])
                            begin
                                res_err_next = bps_pkg::ERR_SLOT_TAKEN;
                            end
                            else
                            begin
                                slots_next[prio_idx]      = 1'b1;
                                ready_bits_next[prio_idx] = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bps_pkg::S_TICK:
            begin
                // issue read for the next entry
                if (!scan_done)
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = idx_reg[bps_pkg::IDX_W-1:0];
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = idx_reg[bps_pkg::IDX_W-1:0];
                    idx_next      = idx_reg + bps_pkg::CNT_W'(1);
                end
                // decrement and write back the entry read last cycle
                if (pipe_vld_reg && delayed_bits_reg[pipe_idx_reg])
                begin
                    if (tval != '0)
                    begin
                        tval = tval - bps_pkg::TICK_BITS'(1);
                    end
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pipe_idx_reg;
                    ram_wr_data = tval;
                    if (tval == '0)
                    begin
                        ready_bits_next[pipe_idx_reg]   = 1'b1;
                        delayed_bits_next[pipe_idx_reg] = 1'b0;
                    end
                end
            end
            bps_pkg::S_SCHED:
            begin
                if (!scan_done)
                begin
                    if (ready_bits_reg[idx_reg[bps_pkg::IDX_W-1:0]])
                    begin
                        best_next = idx_reg + bps_pkg::CNT_W'(1);
                    end
                    idx_next = idx_reg + bps_pkg::CNT_W'(1);
                end
                else
                begin
                    if (best_reg != '0)
                    begin
                        nvalid = 1'b1;
                        nid    = best_reg;
                    end
                    else if (idle_reg)
                    begin
                        nvalid = 1'b1;
                    end
                    res_sw_next    = (nvalid != cur_valid_reg) || (nvalid && nid != cur_reg);
                    cur_valid_next = nvalid;
                    cur_next       = nid;
                end
            end
            bps_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_thread_next = cur_valid_reg ? bps_pkg::THREAD_W'(cur_reg) : '0;
                    out_sw_next     = res_sw_reg;
                    out_mask_next   = ready_mask_full;
                    out_err_next    = res_err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready       = (state_reg == bps_pkg::S_IDLE);
    assign rsp.valid       = out_vld_reg;
    assign rsp.next_thread = out_thread_reg;
    assign rsp.switch_now  = out_sw_reg;
    assign rsp.ready_mask  = out_mask_reg;
    assign rsp.error_code  = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bps_pkg::S_IDLE;
            ready_bits_reg   <= '0;
            delayed_bits_reg <= '0;
            slots_reg        <= '0;
            idle_reg         <= 1'b0;
            cur_reg          <= '0;
            cur_valid_reg    <= 1'b0;
            idx_reg          <= '0;
            pipe_vld_reg     <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ready_bits_reg   <= ready_bits_next;
            delayed_bits_reg <= delayed_bits_next;
            slots_reg        <= slots_next;
            idle_reg         <= idle_next;
            cur_reg          <= cur_next;
            cur_valid_reg    <= cur_valid_next;
            idx_reg          <= idx_next;
            pipe_vld_reg     <= pipe_vld_next;
            out_vld_reg      <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg       <= best_next;
        pipe_idx_reg   <= pipe_idx_next;
        res_sw_reg     <= res_sw_next;
        res_err_reg    <= res_err_next;
        out_thread_reg <= out_thread_next;
        out_sw_reg     <= out_sw_next;
        out_mask_reg   <= out_mask_next;
        out_err_reg    <= out_err_next;
    end

endmodule

@@ sv/bps_ram.sv @@
// ----------------------------------------------------------------------------
// bps_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ bench/bps_sched_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_sched_checker
// Watches the command and result channels of the bitmap priority scheduler,
// keeps its own copy of the ready, delayed and timeout state, predicts the
// outcome of every accepted command and compares each returned result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bps_sched_checker (
    input  logic clk,
    input  logic rst_n,
    bps_req_if   req,
    bps_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding,
    output int   checked
);

    typedef struct packed {
        logic [bps_pkg::THREAD_W-1:0] thread;
        logic                         sw;
        logic [bps_pkg::MASK_W-1:0]   mask;
        bps_pkg::err_t                err;
    } sched_out_t;

    logic [bps_pkg::NUM_PRIOS-1:0] ready_set;
    logic [bps_pkg::NUM_PRIOS-1:0] delayed_set;
    logic [bps_pkg::NUM_PRIOS-1:0] slot_taken;
    logic                          idle_taken;
    logic [bps_pkg::TICK_BITS-1:0] sleep_left [1:bps_pkg::NUM_PRIOS];
    logic [bps_pkg::THREAD_W-1:0]  running;
    logic                          running_valid;
    sched_out_t                    pending_q[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
    end

    function automatic logic pick_next_thread();
        logic                         nvalid;
        logic [bps_pkg::THREAD_W-1:0] nid;
        logic                         sw;
        nvalid = 1'b1;
        nid    = '0;
        if (ready_set != '0)
        begin
            for (int i = 1; i <= bps_pkg::NUM_PRIOS; i++)
            begin
                if (ready_set[i-1])
                    nid = bps_pkg::THREAD_W'(i);
            end
        end
        else if (!idle_taken)
        begin
            nvalid = 1'b0;
        end
        sw = (nvalid != running_valid) || (nvalid && nid != running);
        running_valid = nvalid;
        running       = nid;
        return sw;
    endfunction

    function automatic sched_out_t apply_cmd(bps_pkg::cmd_t c,
                                             logic [bps_pkg::PRIO_W-1:0] p,
                                             logic [bps_pkg::DELAY_W-1:0] t);
        sched_out_t                    o;
        logic [bps_pkg::TICK_BITS-1:0] sleep;
        o.sw  = 1'b0;
        o.err = bps_pkg::ERR_OK;
        sleep = t[bps_pkg::TICK_BITS-1:0];
        case (c)
            bps_pkg::CMD_TICK:
            begin
                for (int i = 1; i <= bps_pkg::NUM_PRIOS; i++)
                begin
                    if (delayed_set[i-1])
                    begin
                        if (sleep_left[i] != '0)
                            sleep_left[i] = sleep_left[i] - 1'b1;
                        if (sleep_left[i] == '0)
                        begin
                            ready_set[i-1]   = 1'b1;
                            delayed_set[i-1] = 1'b0;
                        end
                    end
                end
            end
            bps_pkg::CMD_DELAY:
            begin
                if (!running_valid || running == '0 || running > bps_pkg::NUM_PRIOS)
                begin
                    o.err = bps_pkg::ERR_NO_THREAD;
                end
                else if (sleep == '0)
                begin
                    o.err = bps_pkg::ERR_ZERO_DELAY;
                end
                else
                begin
                    sleep_left[running]    = sleep;
                    ready_set[running-1]   = 1'b0;
                    delayed_set[running-1] = 1'b1;
                    o.sw = pick_next_thread();
                end
            end
            bps_pkg::CMD_START:
            begin
                if (p > bps_pkg::NUM_PRIOS)
                begin
                    o.err = bps_pkg::ERR_SLOT_TAKEN;
                end
                else if (p == '0)
                begin
                    if (idle_taken)
                        o.err = bps_pkg::ERR_SLOT_TAKEN;
                    else
                        idle_taken = 1'b1;
                end
                else if (slot_taken[p-1])
                begin
                    o.err = bps_pkg::ERR_SLOT_TAKEN;
                end
                else
                begin
                    slot_taken[p-1] = 1'b1;
                    sleep_left[p]   = '0;
                    ready_set[p-1]  = 1'b1;
                end
            end
            default:
            begin
                o.sw = pick_next_thread();
            end
        endcase
        o.thread = running_valid ? running : '0;
        o.mask   = bps_pkg::MASK_W'(ready_set);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_out_t want;
        if (!rst_n)
        begin
            ready_set     = '0;
            delayed_set   = '0;
            slot_taken    = '0;
            idle_taken    = 1'b0;
            running       = '0;
            running_valid = 1'b0;
            pending_q.delete();
            outstanding   = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing outstanding",
                                    32'(rsp.ready_mask), 32'd0);
                end
                else
                begin
                    want = pending_q.pop_front();
                    checked++;
                    if (rsp.next_thread !== want.thread)
                        report_mismatch("next_thread", 32'(rsp.next_thread),
                                        32'(want.thread));
                    if (rsp.switch_now !== want.sw)
                        report_mismatch("switch_now", 32'(rsp.switch_now), 32'(want.sw));
                    if (rsp.ready_mask !== want.mask)
                        report_mismatch("ready_mask", 32'(rsp.ready_mask), 32'(want.mask));
                    if (rsp.error_code !== want.err)
                        report_mismatch("error_code", 32'(rsp.error_code), 32'(want.err));
                end
            end
            if (req.valid && req.ready)
                pending_q.push_back(apply_cmd(bps_pkg::cmd_t'(req.cmd), req.prio,
                                              req.delay_ticks));
            outstanding = pending_q.size();
        end
    end

endmodule

@@ bench/bitmap_priority_scheduler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_priority_scheduler_tb
// Drives scheduler commands through a directed sequence covering the error
// paths and wake-up cases, then random thread traffic in four pacing phases
// with a long result hold-off; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module bitmap_priority_scheduler_tb;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 310;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = bps_pkg::NUM_PRIOS + 8;

    logic clk;
    logic rst_n;
    logic rsp_hold    = 1'b0;
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    int   cycle_count = 0;
    int   mismatches;
    int   outstanding;
    int   checked;
    int   sent [4];

    bps_req_if req();
    bps_rsp_if rsp();

    bitmap_priority_scheduler DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    bps_sched_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results outstanding",
                     outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= !rsp_hold && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic hold_results(int cycles);
        rsp_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rsp_hold <= 1'b0;
    endtask

    task automatic issue(bps_pkg::cmd_t c, logic [bps_pkg::PRIO_W-1:0] p,
                         logic [bps_pkg::DELAY_W-1:0] t);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.cmd         <= c;
        req.prio        <= p;
        req.delay_ticks <= t;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent[c]++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    initial
    begin
        bps_pkg::cmd_t               c;
        logic [bps_pkg::PRIO_W-1:0]  p;
        logic [bps_pkg::DELAY_W-1:0] t;
        int                          r;

        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.cmd         = bps_pkg::CMD_TICK;
        req.prio        = '0;
        req.delay_ticks = '0;
        foreach (sent[i])
            sent[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(bps_pkg::CMD_SCHED, '0, '0);
        issue(bps_pkg::CMD_DELAY, '0, 32'd5);
        issue(bps_pkg::CMD_TICK,  '0, '0);
        issue(bps_pkg::CMD_START, 6'd63, '0);
        issue(bps_pkg::CMD_START, 6'd33, '0);
        issue(bps_pkg::CMD_START, 6'd5, '0);
        issue(bps_pkg::CMD_SCHED, '0, '0);
        issue(bps_pkg::CMD_DELAY, '0, '0);
        issue(bps_pkg::CMD_DELAY, '0, 32'd1);
        issue(bps_pkg::CMD_TICK,  '0, '0);
        issue(bps_pkg::CMD_SCHED, '0, '0);
        issue(bps_pkg::CMD_START, 6'd0, '0);
        issue(bps_pkg::CMD_START, 6'd0, '0);
        issue(bps_pkg::CMD_START, 6'd5, '0);
        issue(bps_pkg::CMD_START, bps_pkg::PRIO_W'(bps_pkg::NUM_PRIOS), '0);
        issue(bps_pkg::CMD_START, 6'd1, '0);
        issue(bps_pkg::CMD_TICK,  '0, '0);
        issue(bps_pkg::CMD_SCHED, '0, '0);
        issue(bps_pkg::CMD_DELAY, '0, 32'd2);
        issue(bps_pkg::CMD_TICK,  '0, '0);
        issue(bps_pkg::CMD_TICK,  '0, '0);
        issue(bps_pkg::CMD_SCHED, '0, '0);
        issue(bps_pkg::CMD_DELAY, '0, 32'hFFFF_FFFF);
        issue(bps_pkg::CMD_DELAY, '0, 32'd3);
        issue(bps_pkg::CMD_SCHED, '0, '0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 74; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            if (ph == 2)
            begin
                fork
                    hold_results(HOLD_CYCLES);
                join_none
            end
            repeat (ITEMS_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    c = bps_pkg::CMD_TICK;
                else if (r < 55)
                    c = bps_pkg::CMD_DELAY;
                else if (r < 65)
                    c = bps_pkg::CMD_START;
                else
                    c = bps_pkg::CMD_SCHED;
                if ($urandom_range(0, 9) == 0)
                    p = bps_pkg::PRIO_W'($urandom_range(bps_pkg::NUM_PRIOS + 1, 63));
                else
                    p = bps_pkg::PRIO_W'($urandom_range(0, bps_pkg::NUM_PRIOS));
                r = $urandom_range(0, 99);
                if (r < 6)
                    t = '0;
                else if (r < 90)
                    t = $urandom_range(1, 6);
                else if (r < 99)
                    t = $urandom_range(7, 40);
                else
                    t = $urandom;
                issue(c, p, t);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d ticks, %0d delays, %0d starts, %0d schedules.",
                 sent[bps_pkg::CMD_TICK] + sent[bps_pkg::CMD_DELAY] +
                 sent[bps_pkg::CMD_START] + sent[bps_pkg::CMD_SCHED],
                 sent[bps_pkg::CMD_TICK], sent[bps_pkg::CMD_DELAY],
                 sent[bps_pkg::CMD_START], sent[bps_pkg::CMD_SCHED]);
        $display("%0d results checked over four pacing phases and a %0d-cycle hold-off.",
                 checked, HOLD_CYCLES);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
